FILE: hdl/drle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drle_pkg
// Shared types and constants for the dual run-length encoder.
// ----------------------------------------------------------------------------
package drle_pkg;

    localparam int VOXEL_W       = 32;
    localparam int NODE_W        = 23;
    localparam int LIGHT_W       = 8;
    localparam int LIGHT_LSB     = 23;
    localparam int NODE_MAX_RUN  = 512;
    localparam int LIGHT_MAX_RUN = 256;
    localparam int NODE_CNT_W    = 10;
    localparam int LIGHT_CNT_W   = 9;
    localparam int NODE_LEN_W    = 9;
    localparam int LIGHT_LEN_W   = 8;
    localparam int NODE_WORD_W   = NODE_W + NODE_LEN_W;
    localparam int LIGHT_WORD_W  = LIGHT_W + LIGHT_LEN_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    // One decoded voxel as it travels from the front to the back.
    typedef struct packed {
        logic [NODE_W-1:0]  node_val;
        logic [LIGHT_W-1:0] light_lvl;
        logic               last;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic                    node_valid;
        logic [NODE_WORD_W-1:0]  node_word;
        logic                    light_valid;
        logic [LIGHT_WORD_W-1:0] light_word;
        logic                    last;
    } result_t;

    // Handshake between the queue head and the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

FILE: hdl/drle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drle_front
// Accepts voxel words, splits them into node and light values and holds
// them in a short register queue for the encoder back end.
// ----------------------------------------------------------------------------
module drle_front #(
    parameter int DEPTH = drle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [drle_pkg::VOXEL_W-1:0]  s_voxel_word,
    input  logic                          s_last_in,
    output drle_pkg::head_t               head,
    input  logic                          head_pop
);
    import drle_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         queue_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    item_t         in_item;
    logic          push;
    logic          pop;

    assign s_ready = (count_reg != CW'(DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = head_pop && (count_reg != '0);

    always_comb begin
        in_item.node_val  = s_voxel_word[NODE_W-1:0];
        in_item.light_lvl = s_voxel_word[LIGHT_LSB +: LIGHT_W];
        in_item.last      = s_last_in;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count exceeds its depth");

endmodule

FILE: hdl/drle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drle_back
// Run-length encoder proper: extends or closes the node and light runs for
// each queued voxel and drives the registered result channel.
// ----------------------------------------------------------------------------
module drle_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  drle_pkg::head_t                    head,
    output logic                               head_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_node_valid,
    output logic [drle_pkg::NODE_WORD_W-1:0]   m_node_run_word,
    output logic                               m_light_valid,
    output logic [drle_pkg::LIGHT_WORD_W-1:0]  m_light_run_word,
    output logic                               m_last_out
);
    import drle_pkg::*;

    logic [NODE_W-1:0]      node_value_reg, node_value_next;
    logic [NODE_CNT_W-1:0]  node_count_reg, node_count_next;
    logic [LIGHT_W-1:0]     light_value_reg, light_value_next;
    logic [LIGHT_CNT_W-1:0] light_count_reg, light_count_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    pend_reg, pend_next;
    result_t pend_res_reg, pend_res_next;

    logic                   out_free;
    logic                   node_start, node_ext, node_close;
    logic                   light_start, light_ext, light_close;
    logic [NODE_CNT_W-1:0]  node_cnt_upd, node_cnt_m1, node_upd_m1;
    logic [LIGHT_CNT_W-1:0] light_cnt_upd, light_cnt_m1, light_upd_m1;
    result_t                close_res, flush_res;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        node_start = (node_count_reg == '0);
        node_ext   = !node_start && (head.item.node_val == node_value_reg)
                     && (node_count_reg < NODE_CNT_W'(NODE_MAX_RUN));
        node_close = !node_start && !node_ext;
        node_cnt_upd = node_ext ? node_count_reg + 1'b1 : NODE_CNT_W'(1);
        node_cnt_m1  = node_count_reg - 1'b1;
        node_upd_m1  = node_cnt_upd - 1'b1;

        light_start = (light_count_reg == '0);
        light_ext   = !light_start && (head.item.light_lvl == light_value_reg)
                      && (light_count_reg < LIGHT_CNT_W'(LIGHT_MAX_RUN));
        light_close = !light_start && !light_ext;
        light_cnt_upd = light_ext ? light_count_reg + 1'b1 : LIGHT_CNT_W'(1);
        light_cnt_m1  = light_count_reg - 1'b1;
        light_upd_m1  = light_cnt_upd - 1'b1;

        // A word whose valid bit is low goes out as zero.
        close_res.node_valid  = node_close;
        close_res.node_word   = node_close ?
            {node_cnt_m1[NODE_LEN_W-1:0], node_value_reg} : '0;
        close_res.light_valid = light_close;
        close_res.light_word  = light_close ?
            {light_cnt_m1[LIGHT_LEN_W-1:0], light_value_reg} : '0;
        close_res.last        = 1'b0;

        // The flush covers the runs as they stand after this voxel.
        flush_res.node_valid  = 1'b1;
        flush_res.node_word   = {node_upd_m1[NODE_LEN_W-1:0], head.item.node_val};
        flush_res.light_valid = 1'b1;
        flush_res.light_word  = {light_upd_m1[LIGHT_LEN_W-1:0], head.item.light_lvl};
        flush_res.last        = 1'b1;
    end

    always_comb begin
        node_value_next  = node_value_reg;
        node_count_next  = node_count_reg;
        light_value_next = light_value_reg;
        light_count_next = light_count_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_next         = out_reg;
        pend_next        = pend_reg;
        pend_res_next    = pend_res_reg;
        head_pop         = 1'b0;

        if (out_free) begin
            if (pend_reg) begin
                out_valid_next = 1'b1;
                out_next       = pend_res_reg;
                pend_next      = 1'b0;
            end else if (head.valid) begin
                head_pop         = 1'b1;
                node_value_next  = head.item.node_val;
                node_count_next  = head.item.last ? '0 : node_cnt_upd;
                light_value_next = head.item.light_lvl;
                light_count_next = head.item.last ? '0 : light_cnt_upd;
                if (node_close || light_close) begin
                    out_valid_next = 1'b1;
                    out_next       = close_res;
                    if (head.item.last) begin
                        pend_next     = 1'b1;
                        pend_res_next = flush_res;
                    end
                end else if (head.item.last) begin
                    out_valid_next = 1'b1;
                    out_next       = flush_res;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_value_reg  <= '0;
            node_count_reg  <= '0;
            light_value_reg <= '0;
            light_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            pend_reg        <= 1'b0;
        end else begin
            node_value_reg  <= node_value_next;
            node_count_reg  <= node_count_next;
            light_value_reg <= light_value_next;
            light_count_reg <= light_count_next;
            out_valid_reg   <= out_valid_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        pend_res_reg <= pend_res_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_node_valid     = out_reg.node_valid;
    assign m_node_run_word  = out_reg.node_word;
    assign m_light_valid    = out_reg.light_valid;
    assign m_light_run_word = out_reg.light_word;
    assign m_last_out       = out_reg.last;

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> out_valid_reg)
        else $error("pending flush without a result ahead of it");

    a_pend_runs_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (node_count_reg == '0 && light_count_reg == '0))
        else $error("runs still open while a flush is pending");

    a_node_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        node_count_reg <= NODE_CNT_W'(NODE_MAX_RUN))
        else $error("node run longer than its maximum");

    a_light_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        light_count_reg <= LIGHT_CNT_W'(LIGHT_MAX_RUN))
        else $error("light run longer than its maximum");

    a_flush_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.last) |-> (out_reg.node_valid && out_reg.light_valid))
        else $error("final result lacks a node or light run");

endmodule

FILE: hdl/dual_run_length_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_run_length_encoder_unit
// Run-length encodes the node and light fields of a voxel stream at once.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  s_       | in        | s_valid / s_ready  | s_voxel_word, s_last_in
//  m_       | out       | m_valid / m_ready  | m_node_valid, m_node_run_word,
//           |           |                    | m_light_valid, m_light_run_word,
//           |           |                    | m_last_out
//
//  One voxel per cycle is sustained while the output is not stalled and no
//  flush is pending; the back end then retires one queued voxel per cycle. A
//  last voxel that closes a run yields two results through the single output
//  register. Input reaches the result via the queue, then the output register.
//  Reset is synchronous and active low; it clears the queue and open runs.
//  A stalled output holds the back end; the queue keeps taking input until
//  it is full.
// ----------------------------------------------------------------------------
module dual_run_length_encoder_unit #(
    parameter int QUEUE_DEPTH = drle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [drle_pkg::VOXEL_W-1:0]       s_voxel_word,
    input  logic                               s_last_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_node_valid,
    output logic [drle_pkg::NODE_WORD_W-1:0]   m_node_run_word,
    output logic                               m_light_valid,
    output logic [drle_pkg::LIGHT_WORD_W-1:0]  m_light_run_word,
    output logic                               m_last_out
);
    import drle_pkg::*;

    head_t head;
    logic  head_pop;

    drle_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_voxel_word (s_voxel_word),
        .s_last_in    (s_last_in),
        .head         (head),
        .head_pop     (head_pop)
    );

    drle_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .head_pop         (head_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_node_valid     (m_node_valid),
        .m_node_run_word  (m_node_run_word),
        .m_light_valid    (m_light_valid),
        .m_light_run_word (m_light_run_word),
        .m_last_out       (m_last_out)
    );

endmodule
